/* hw/rtl/tcr_pkg.sv */
// Shared constants, types and helper functions of the turn-indexed command ring.
`default_nettype none

package tcr_pkg;

  // Sizing of the ring.
  localparam int RING_DEPTH    = 64;
  localparam int PLAYER_COUNT  = 4;
  localparam int COMMAND_WIDTH = 16;
  localparam int TURN_WIDTH    = 32;

  // Fixed field widths of the request and result items.
  localparam int FUNC_W   = 3;
  localparam int PLAYER_W = 3;
  localparam int OFFSET_W = 6;
  localparam int STATUS_W = 2;

  // Derived widths.
  localparam int IDX_W     = $clog2(RING_DEPTH);
  localparam int CNT_W     = $clog2(RING_DEPTH + 1);
  localparam int LANE_W    = (PLAYER_COUNT > 1) ? $clog2(PLAYER_COUNT) : 1;
  localparam int PLAYERC_W = PLAYER_W + 1;
  localparam int NEEDC_W   = (TURN_WIDTH > CNT_W) ? TURN_WIDTH : CNT_W;
  localparam int OFFC_W    = (OFFSET_W > CNT_W) ? OFFSET_W : CNT_W;

  // Reset value of the pass code register.
  localparam logic [COMMAND_WIDTH-1:0] PASS_RESET = COMMAND_WIDTH'(1);

  // Operation codes carried by the func field.
  typedef enum logic [FUNC_W-1:0] {
    FUNC_CLEAR = 3'd0,
    FUNC_PUSH  = 3'd1,
    FUNC_POP   = 3'd2,
    FUNC_PEEK  = 3'd3,
    FUNC_SIZE  = 3'd4
  } func_e;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK         = 2'd0,
    STAT_EMPTY      = 2'd1,
    STAT_OVERFLOW   = 2'd2,
    STAT_BAD_PLAYER = 2'd3
  } status_e;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_PUSH_CHK,
    S_APPEND,
    S_SEARCH,
    S_WRITE,
    S_EMIT_ONE,
    S_EMIT_ENTRY
  } state_e;

  // One ring entry's command words, one lane per player.
  typedef logic [PLAYER_COUNT-1:0][COMMAND_WIDTH-1:0] row_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    capture;
    logic    clear_ring;
    logic    load_need;
    logic    append;
    logic    search_init;
    logic    search_en;
    logic    write_cmd;
    logic    pop_adv;
    logic    rd_head;
    logic    rd_peek;
    logic    load_resp;
    status_e resp_status;
    logic    resp_push;
    logic    lane_clr;
    logic    lane_inc;
    logic    emit_entry;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    func_e func;
    logic  bad_player;
    logic  overflow;
    logic  need_zero;
    logic  need_last;
    logic  empty;
    logic  peek_bad;
    logic  hit;
    logic  lane_last;
  } dp_stat_t;

  // Ring slot at an offset from a base slot; the offset never exceeds the depth.
  function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] base,
                                                input logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(off);
    if (sum >= (CNT_W + 1)'(RING_DEPTH)) begin
      sum = sum - (CNT_W + 1)'(RING_DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/tcr_datapath.sv */
// Datapath of the command ring: entry memories, pointers, search pipeline and result registers.
`default_nettype none

module tcr_datapath (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic [tcr_pkg::FUNC_W-1:0]            func_i,
  input  wire logic [tcr_pkg::TURN_WIDTH-1:0]        turn_i,
  input  wire logic [tcr_pkg::PLAYER_W-1:0]          player_i,
  input  wire logic [tcr_pkg::COMMAND_WIDTH-1:0]     command_i,
  input  wire logic [tcr_pkg::OFFSET_W-1:0]          order_index_i,
  input  wire logic                                  cfg_we_i,
  input  wire logic [tcr_pkg::COMMAND_WIDTH-1:0]     cfg_wdata_i,
  input  wire tcr_pkg::dp_cmd_t                      cmd_i,
  output tcr_pkg::dp_stat_t                          stat_o,
  output logic [tcr_pkg::STATUS_W-1:0]               status_o,
  output logic [tcr_pkg::TURN_WIDTH-1:0]             turn_out_o,
  output logic [tcr_pkg::PLAYER_W-1:0]               player_out_o,
  output logic [tcr_pkg::COMMAND_WIDTH-1:0]          command_out_o,
  output logic [tcr_pkg::CNT_W-1:0]                  count_o,
  output logic                                       last_o
);

  localparam int RD  = tcr_pkg::RING_DEPTH;
  localparam int PC  = tcr_pkg::PLAYER_COUNT;
  localparam int CW  = tcr_pkg::COMMAND_WIDTH;
  localparam int TW  = tcr_pkg::TURN_WIDTH;
  localparam int IW  = tcr_pkg::IDX_W;
  localparam int NW  = tcr_pkg::CNT_W;
  localparam int LW  = tcr_pkg::LANE_W;

  // Entry memories: turn numbers and command rows.
  logic [TW-1:0]     turn_mem [RD];
  tcr_pkg::row_t     row_mem  [RD];

  // Ring pointers and bookkeeping.
  logic [IW-1:0]     head_q, head_d;
  logic [NW-1:0]     count_q, count_d;
  logic [TW-1:0]     tail_q, tail_d;
  logic [CW-1:0]     pass_code_q;
  logic [CW-1:0]     init_cmd_q, init_cmd_d;
  logic              pend_turn_q, pend_turn_d;
  logic [PC-1:0]     pend_cmd_q, pend_cmd_d;

  // Captured request.
  logic [tcr_pkg::FUNC_W-1:0]   func_q;
  logic [TW-1:0]                turn_in_q;
  logic [tcr_pkg::PLAYER_W-1:0] player_in_q;
  logic [CW-1:0]                cmd_in_q;
  logic [tcr_pkg::OFFSET_W-1:0] off_in_q;

  // Push bookkeeping and search pipeline.
  logic [TW-1:0]     need_q, need_d;
  logic [NW-1:0]     k_q;
  logic              rd_v_q;
  logic              rd_last_q;
  logic [IW-1:0]     rd_slot_q;
  logic [IW-1:0]     found_slot_q;
  logic [TW-1:0]     found_turn_q;

  // Registered memory read data and the reset overlay that goes with it.
  logic [TW-1:0]     turn_rd_q;
  tcr_pkg::row_t     row_rd_q;
  logic              rd_pend_turn_q;
  logic [PC-1:0]     rd_pend_cmd_q;

  // Single-result registers and the lane counter.
  tcr_pkg::status_e  resp_status_q;
  logic [TW-1:0]     resp_turn_q;
  logic [tcr_pkg::PLAYER_W-1:0] resp_player_q;
  logic [CW-1:0]     resp_cmd_q;
  logic [LW-1:0]     lane_q;

  // Combinational helpers.
  logic [IW-1:0]     tail_slot;
  logic [IW-1:0]     search_slot;
  logic [IW-1:0]     peek_slot;
  logic [IW-1:0]     rd_addr;
  logic [IW-1:0]     wr_addr;
  logic              rd_en;
  logic              search_issue;
  logic [TW-1:0]     append_turn;
  logic [NW-1:0]     room;
  logic [TW-1:0]     turn_eff;
  tcr_pkg::row_t     row_eff;
  tcr_pkg::row_t     row_wdata;
  logic [PC-1:0]     row_we;
  logic              turn_we;
  logic              ge_hit;

  assign tail_slot    = tcr_pkg::wrap_add(head_q, count_q);
  assign search_slot  = tcr_pkg::wrap_add(head_q, k_q);
  assign peek_slot    = tcr_pkg::wrap_add(head_q, NW'(off_in_q));
  assign search_issue = cmd_i.search_en && (k_q < count_q);
  assign rd_en        = cmd_i.rd_head || cmd_i.rd_peek || search_issue;
  assign append_turn  = (count_q == '0) ? turn_in_q : tail_q + TW'(1);
  assign room         = NW'(RD) - count_q;

  // Read address: the search walk, a peek offset or the head.
  always_comb begin
    if (search_issue) begin
      rd_addr = search_slot;
    end else if (cmd_i.rd_peek) begin
      rd_addr = peek_slot;
    end else begin
      rd_addr = head_q;
    end
  end

  // Write port: an appended entry is cleared in full, a push writes one lane.
  always_comb begin
    wr_addr   = cmd_i.append ? tail_slot : found_slot_q;
    turn_we   = cmd_i.append;
    row_we    = '0;
    row_wdata = '0;
    for (int l = 0; l < PC; l++) begin
      if (cmd_i.append) begin
        row_we[l] = 1'b1;
      end else if (cmd_i.write_cmd && (player_in_q == tcr_pkg::PLAYER_W'(l))) begin
        row_we[l]    = 1'b1;
        row_wdata[l] = cmd_in_q;
      end
    end
  end

  // Entry memories, written and read in clocked blocks.
  always_ff @(posedge clk_i) begin
    if (turn_we) begin
      turn_mem[wr_addr] <= append_turn;
    end
    for (int l = 0; l < PC; l++) begin
      if (row_we[l]) begin
        row_mem[wr_addr][l] <= row_wdata[l];
      end
    end
    if (rd_en) begin
      turn_rd_q      <= turn_mem[rd_addr];
      row_rd_q       <= row_mem[rd_addr];
      rd_pend_turn_q <= pend_turn_q && (rd_addr == '0);
      rd_pend_cmd_q  <= pend_cmd_q & {PC{rd_addr == '0}};
    end
  end

  // Slot zero reads as the cleared turn zero until it is written again.
  always_comb begin
    turn_eff = rd_pend_turn_q ? '0 : turn_rd_q;
    for (int l = 0; l < PC; l++) begin
      row_eff[l] = rd_pend_cmd_q[l] ? init_cmd_q : row_rd_q[l];
    end
  end

  assign ge_hit = turn_eff >= turn_in_q;

  // Next values of the ring bookkeeping.
  always_comb begin
    head_d      = head_q;
    count_d     = count_q;
    tail_d      = tail_q;
    init_cmd_d  = init_cmd_q;
    pend_turn_d = pend_turn_q;
    pend_cmd_d  = pend_cmd_q;
    need_d      = need_q;
    if (cmd_i.clear_ring) begin
      head_d      = '0;
      count_d     = NW'(1);
      tail_d      = '0;
      init_cmd_d  = pass_code_q;
      pend_turn_d = 1'b1;
      pend_cmd_d  = '1;
    end
    if (cmd_i.load_need) begin
      if (count_q == '0) begin
        need_d = TW'(1);
      end else if (turn_in_q > tail_q) begin
        need_d = turn_in_q - tail_q;
      end else begin
        need_d = '0;
      end
    end
    if (cmd_i.append) begin
      count_d = count_q + NW'(1);
      tail_d  = append_turn;
      need_d  = need_q - TW'(1);
      if (tail_slot == '0) begin
        pend_turn_d = 1'b0;
        pend_cmd_d  = '0;
      end
    end
    if (cmd_i.write_cmd && (found_slot_q == '0)) begin
      pend_cmd_d = pend_cmd_q & ~row_we;
    end
    if (cmd_i.pop_adv) begin
      head_d  = tcr_pkg::wrap_add(head_q, NW'(1));
      count_d = count_q - NW'(1);
    end
  end

  // Control registers of the ring.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      count_q     <= NW'(1);
      tail_q      <= '0;
      pass_code_q <= tcr_pkg::PASS_RESET;
      init_cmd_q  <= tcr_pkg::PASS_RESET;
      pend_turn_q <= 1'b1;
      pend_cmd_q  <= '1;
      k_q         <= '0;
      rd_v_q      <= 1'b0;
      lane_q      <= '0;
    end else begin
      head_q      <= head_d;
      count_q     <= count_d;
      tail_q      <= tail_d;
      init_cmd_q  <= init_cmd_d;
      pend_turn_q <= pend_turn_d;
      pend_cmd_q  <= pend_cmd_d;
      if (cfg_we_i) begin
        pass_code_q <= cfg_wdata_i;
      end
      if (cmd_i.search_init) begin
        k_q    <= '0;
        rd_v_q <= 1'b0;
      end else if (cmd_i.search_en) begin
        rd_v_q <= search_issue;
        if (search_issue) begin
          k_q <= k_q + NW'(1);
        end
      end
      if (cmd_i.lane_clr) begin
        lane_q <= '0;
      end else if (cmd_i.lane_inc) begin
        lane_q <= lane_q + LW'(1);
      end
    end
  end

  // Payload registers: request capture, search results and single results.
  always_ff @(posedge clk_i) begin
    need_q <= need_d;
    if (cmd_i.capture) begin
      func_q      <= func_i;
      turn_in_q   <= turn_i;
      player_in_q <= player_i;
      cmd_in_q    <= command_i;
      off_in_q    <= order_index_i;
    end
    if (search_issue) begin
      rd_slot_q <= search_slot;
      rd_last_q <= (k_q == count_q - NW'(1));
    end
    if (cmd_i.search_en && stat_o.hit) begin
      found_slot_q <= rd_slot_q;
      found_turn_q <= turn_eff;
    end
    if (cmd_i.load_resp) begin
      resp_status_q <= cmd_i.resp_status;
      if (cmd_i.resp_push) begin
        resp_turn_q   <= found_turn_q;
        resp_player_q <= player_in_q;
        resp_cmd_q    <= cmd_in_q;
      end else begin
        resp_turn_q   <= '0;
        resp_player_q <= '0;
        resp_cmd_q    <= '0;
      end
    end
  end

  // Status toward the controller.
  always_comb begin
    stat_o.func       = tcr_pkg::func_e'(func_q);
    stat_o.bad_player = {1'b0, player_in_q} >= tcr_pkg::PLAYERC_W'(PC);
    stat_o.overflow   = tcr_pkg::NEEDC_W'(need_q) > tcr_pkg::NEEDC_W'(room);
    stat_o.need_zero  = (need_q == '0);
    stat_o.need_last  = (need_q == TW'(1));
    stat_o.empty      = (count_q == '0);
    stat_o.peek_bad   = (count_q == '0) ||
                        (tcr_pkg::OFFC_W'(off_in_q) >= tcr_pkg::OFFC_W'(count_q));
    stat_o.hit        = rd_v_q && (ge_hit || rd_last_q);
    stat_o.lane_last  = (lane_q == LW'(PC - 1));
  end

  // Result fields: one lane of an entry, or a single result.
  always_comb begin
    count_o = count_q;
    if (cmd_i.emit_entry) begin
      status_o      = tcr_pkg::STAT_OK;
      turn_out_o    = turn_eff;
      player_out_o  = tcr_pkg::PLAYER_W'(lane_q);
      command_out_o = row_eff[lane_q];
      last_o        = stat_o.lane_last;
    end else begin
      status_o      = resp_status_q;
      turn_out_o    = resp_turn_q;
      player_out_o  = resp_player_q;
      command_out_o = resp_cmd_q;
      last_o        = 1'b1;
    end
  end

  // An append never runs into a full ring.
  a_append_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.append |-> (count_q < NW'(RD)))
    else $error("append issued with a full ring");

  // Clearing the ring leaves one entry at slot zero.
  a_clear_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear_ring |=> (count_q == NW'(1)) && (head_q == '0) && pend_turn_q)
    else $error("ring clear did not leave a single entry at slot zero");

  // A push only writes a valid player lane.
  a_write_player: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.write_cmd |-> ({1'b0, player_in_q} < tcr_pkg::PLAYERC_W'(PC)))
    else $error("command written for a player outside the ring");

  // A pop only happens on a ring that holds an entry.
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop_adv |-> (count_q != '0) && cmd_i.rd_head)
    else $error("pop issued on an empty ring");

endmodule

`default_nettype wire

/* hw/rtl/tcr_ctrl.sv */
// Controller state machine of the command ring.
`default_nettype none

module tcr_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire logic               out_stall_i,
  input  wire tcr_pkg::dp_stat_t  stat_i,
  output tcr_pkg::dp_cmd_t        cmd_o,
  output logic                    in_stall_o,
  output logic                    out_valid_o
);

  tcr_pkg::state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tcr_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      tcr_pkg::S_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.capture = in_valid_i;
        if (in_valid_i) begin
          state_d = tcr_pkg::S_DECODE;
        end
      end
      tcr_pkg::S_DECODE: begin
        case (stat_i.func)
          tcr_pkg::FUNC_CLEAR: begin
            cmd_o.clear_ring  = 1'b1;
            cmd_o.load_resp   = 1'b1;
            cmd_o.resp_status = tcr_pkg::STAT_OK;
            state_d           = tcr_pkg::S_EMIT_ONE;
          end
          tcr_pkg::FUNC_PUSH: begin
            cmd_o.load_need = 1'b1;
            state_d         = tcr_pkg::S_PUSH_CHK;
          end
          tcr_pkg::FUNC_POP: begin
            if (stat_i.empty) begin
              cmd_o.load_resp   = 1'b1;
              cmd_o.resp_status = tcr_pkg::STAT_EMPTY;
              state_d           = tcr_pkg::S_EMIT_ONE;
            end else begin
              cmd_o.rd_head  = 1'b1;
              cmd_o.pop_adv  = 1'b1;
              cmd_o.lane_clr = 1'b1;
              state_d        = tcr_pkg::S_EMIT_ENTRY;
            end
          end
          tcr_pkg::FUNC_PEEK: begin
            if (stat_i.peek_bad) begin
              cmd_o.load_resp   = 1'b1;
              cmd_o.resp_status = tcr_pkg::STAT_EMPTY;
              state_d           = tcr_pkg::S_EMIT_ONE;
            end else begin
              cmd_o.rd_peek  = 1'b1;
              cmd_o.lane_clr = 1'b1;
              state_d        = tcr_pkg::S_EMIT_ENTRY;
            end
          end
          default: begin
            // Size and the unused codes report the count only.
            cmd_o.load_resp   = 1'b1;
            cmd_o.resp_status = tcr_pkg::STAT_OK;
            state_d           = tcr_pkg::S_EMIT_ONE;
          end
        endcase
      end
      tcr_pkg::S_PUSH_CHK: begin
        if (stat_i.bad_player) begin
          cmd_o.load_resp   = 1'b1;
          cmd_o.resp_status = tcr_pkg::STAT_BAD_PLAYER;
          state_d           = tcr_pkg::S_EMIT_ONE;
        end else if (stat_i.overflow) begin
          cmd_o.load_resp   = 1'b1;
          cmd_o.resp_status = tcr_pkg::STAT_OVERFLOW;
          state_d           = tcr_pkg::S_EMIT_ONE;
        end else if (stat_i.need_zero) begin
          cmd_o.search_init = 1'b1;
          state_d           = tcr_pkg::S_SEARCH;
        end else begin
          state_d = tcr_pkg::S_APPEND;
        end
      end
      tcr_pkg::S_APPEND: begin
        // One new tail entry per cycle until the requested turn exists.
        cmd_o.append = 1'b1;
        if (stat_i.need_last) begin
          cmd_o.search_init = 1'b1;
          state_d           = tcr_pkg::S_SEARCH;
        end
      end
      tcr_pkg::S_SEARCH: begin
        cmd_o.search_en = 1'b1;
        if (stat_i.hit) begin
          state_d = tcr_pkg::S_WRITE;
        end
      end
      tcr_pkg::S_WRITE: begin
        cmd_o.write_cmd   = 1'b1;
        cmd_o.load_resp   = 1'b1;
        cmd_o.resp_status = tcr_pkg::STAT_OK;
        cmd_o.resp_push   = 1'b1;
        state_d           = tcr_pkg::S_EMIT_ONE;
      end
      tcr_pkg::S_EMIT_ONE: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          state_d = tcr_pkg::S_IDLE;
        end
      end
      tcr_pkg::S_EMIT_ENTRY: begin
        out_valid_o      = 1'b1;
        cmd_o.emit_entry = 1'b1;
        if (!out_stall_i) begin
          if (stat_i.lane_last) begin
            state_d = tcr_pkg::S_IDLE;
          end else begin
            cmd_o.lane_inc = 1'b1;
          end
        end
      end
      default: begin
        state_d = tcr_pkg::S_IDLE;
      end
    endcase
  end

  // A taken request always moves the controller into decode.
  a_accept_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == tcr_pkg::S_DECODE))
    else $error("accepted request was not decoded");

endmodule

`default_nettype wire

/* hw/rtl/turn_indexed_command_ring.sv */
// Top level of the turn-indexed command ring: controller and datapath.
//
// A ring of consecutively numbered turns, each holding one command word per
// player. Requests arrive on the in_* channel (valid/stall) and results leave
// on the out_* channel; a request is taken when valid is high and stall low.
// Clear, size, push and all error cases give one result; pop and peek give
// one result per player, with last set on the final one.
// One request is worked at a time. Clear, size, an empty pop and an
// out-of-range peek go from decode straight to their result, and a refused
// push from decode through the push check. Pop and peek read the entry in
// decode and then give the results of the players in turn. A push goes through
// decode, the push check, any append of new tail turns (one per cycle through
// the write port), the search (one entry per cycle through the registered turn
// memory read port), the command write and the result.
// The next request is taken the cycle after the last result is delivered.
// While the receiver stalls, the current result holds and no request is taken.
// Reset leaves one turn zero whose slots read as the pass code reset value;
// there is no clearing pass. The pass code register is written through
// cfg_we_i/cfg_wdata_i and is used by the next clear request.
`default_nettype none

module turn_indexed_command_ring (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [tcr_pkg::FUNC_W-1:0]        func_i,
  input  wire logic [tcr_pkg::TURN_WIDTH-1:0]    turn_i,
  input  wire logic [tcr_pkg::PLAYER_W-1:0]      player_i,
  input  wire logic [tcr_pkg::COMMAND_WIDTH-1:0] command_i,
  input  wire logic [tcr_pkg::OFFSET_W-1:0]      order_index_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic [tcr_pkg::STATUS_W-1:0]           status_o,
  output logic [tcr_pkg::TURN_WIDTH-1:0]         turn_out_o,
  output logic [tcr_pkg::PLAYER_W-1:0]           player_out_o,
  output logic [tcr_pkg::COMMAND_WIDTH-1:0]      command_out_o,
  output logic [tcr_pkg::CNT_W-1:0]              count_o,
  output logic                                   last_o,
  input  wire logic                              cfg_we_i,
  input  wire logic [tcr_pkg::COMMAND_WIDTH-1:0] cfg_wdata_i
);

  tcr_pkg::dp_cmd_t  dp_cmd;
  tcr_pkg::dp_stat_t dp_stat;

  // Sequencing of each request.
  tcr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_stall_i (out_stall_i),
    .stat_i      (dp_stat),
    .cmd_o       (dp_cmd),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o)
  );

  // Ring storage and result registers.
  tcr_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .func_i        (func_i),
    .turn_i        (turn_i),
    .player_i      (player_i),
    .command_i     (command_i),
    .order_index_i (order_index_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .cmd_i         (dp_cmd),
    .stat_o        (dp_stat),
    .status_o      (status_o),
    .turn_out_o    (turn_out_o),
    .player_out_o  (player_out_o),
    .command_out_o (command_out_o),
    .count_o       (count_o),
    .last_o        (last_o)
  );

endmodule

`default_nettype wire
